[hw/rtl/bba_pkg.sv]
// ----------------------------------------------------------------------------
// bba_pkg
// Shared widths, codes and defaults of the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int KIND_W = 2;
  localparam int BLK_W  = 10;
  localparam int STAT_W = 3;
  localparam int CFG_W  = 11;

  localparam int NUM_BLOCKS_DEF = 1024;
  localparam int WORD_BITS_DEF  = 32;

  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_OCCUPY  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_DONE  = 3'd0;
  localparam logic [STAT_W-1:0] STAT_USED  = 3'd1;
  localparam logic [STAT_W-1:0] STAT_FREE  = 3'd2;
  localparam logic [STAT_W-1:0] STAT_FULL  = 3'd3;
  localparam logic [STAT_W-1:0] STAT_RANGE = 3'd4;

endpackage

[hw/rtl/bba_if.sv]
// ----------------------------------------------------------------------------
// bba request and response channels
// Valid/ready channels carrying allocator requests and results.
// ----------------------------------------------------------------------------
interface bba_req_if import bba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [BLK_W-1:0]  block_number;

  modport source (output valid, output kind, output block_number, input ready);
  modport sink   (input valid, input kind, input block_number, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [BLK_W-1:0]  result_block;

  modport source (output valid, output status, output result_block, input ready);
  modport sink   (input valid, input status, input result_block, output ready);
endinterface

[hw/rtl/bba_map_ram.sv]
// ----------------------------------------------------------------------------
// bba_map_ram
// Bitmap word memory, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module bba_map_ram #(
  parameter int WORD_BITS = 32,
  parameter int DEPTH     = 32,
  parameter int ADDR_W    = 5
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [ADDR_W-1:0]    waddr_i,
  input  logic [WORD_BITS-1:0] wdata_i,
  input  logic                 re_i,
  input  logic [ADDR_W-1:0]    raddr_i,
  output logic [WORD_BITS-1:0] rdata_o
);

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    // read data holds until the next read
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/bba_ctrl.sv]
// ----------------------------------------------------------------------------
// bba_ctrl
// Request sequencer: map clearing, read-modify-write of named blocks and
// first-fit scan, with the result register.
// ----------------------------------------------------------------------------
module bba_ctrl import bba_pkg::*; #(
  parameter int WORD_BITS  = WORD_BITS_DEF,
  parameter int DEPTH      = 32,
  parameter int ADDR_W     = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [CFG_W-1:0]     lim_i,
  bba_req_if.sink              req_i,
  bba_rsp_if.source            rsp_o,
  output logic                 ram_we_o,
  output logic [ADDR_W-1:0]    ram_waddr_o,
  output logic [WORD_BITS-1:0] ram_wdata_o,
  output logic                 ram_re_o,
  output logic [ADDR_W-1:0]    ram_raddr_o,
  input  logic [WORD_BITS-1:0] ram_rdata_i
);

  localparam int BIT_W  = $clog2(WORD_BITS);
  localparam int SH     = BLK_W + BIT_W;
  localparam int RECIP  = ((1 << SH) + WORD_BITS - 1) / WORD_BITS;
  localparam int PROD_W = BLK_W + SH + 2;
  localparam int BASE_W = CFG_W + 1;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_RD    = 3'd3;
  localparam logic [2:0] ST_MOD   = 3'd4;
  localparam logic [2:0] ST_SCAN  = 3'd5;
  localparam logic [2:0] ST_FAIL  = 3'd6;

  logic [2:0]         state_q, state_d;
  logic [ADDR_W-1:0]  clr_q, clr_d;
  logic [KIND_W-1:0]  kind_q, kind_d;
  logic [BLK_W-1:0]   blk_q, blk_d;
  logic [ADDR_W-1:0]  word_q, word_d;
  logic [BIT_W-1:0]   bit_q, bit_d;
  logic [BASE_W-1:0]  base_q, base_d;
  logic [STAT_W-1:0]  stat_q, stat_d;
  logic               rsp_valid_q, rsp_valid_d;
  logic [STAT_W-1:0]  rsp_stat_q, rsp_stat_d;
  logic [BLK_W-1:0]   rsp_blk_q, rsp_blk_d;

  logic                 accept;
  logic                 out_free;
  logic [PROD_W-1:0]    prod;
  logic [BLK_W-1:0]     word_base;
  logic [CFG_W-1:0]     rem;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] free_bits;
  logic [WORD_BITS-1:0] low_bit;
  logic [BIT_W-1:0]     pick;
  logic                 last_word;
  logic [BASE_W-1:0]    alloc_blk;
  logic                 bit_used;
  logic [WORD_BITS-1:0] bit_sel;

  assign req_i.ready        = (state_q == ST_IDLE);
  assign accept             = req_i.valid && req_i.ready;
  assign out_free           = !rsp_valid_q || rsp_o.ready;
  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = rsp_stat_q;
  assign rsp_o.result_block = rsp_blk_q;

  // word index of a named block by reciprocal multiply, exact for 10-bit input
  assign prod      = PROD_W'(blk_q) * PROD_W'(RECIP);
  assign word_base = BLK_W'(word_q) * BLK_W'(WORD_BITS);

  // first-fit search inside the current word, bits past the limit masked off
  assign rem = lim_i - base_q[CFG_W-1:0];
  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      mask[b] = (rem > CFG_W'(b));
    end
  end
  assign free_bits = ~ram_rdata_i & mask;
  assign low_bit   = free_bits & (~free_bits + 1'b1);
  always_comb begin
    pick = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      pick = pick | (low_bit[b] ? BIT_W'(b) : '0);
    end
  end
  assign last_word = (base_q + BASE_W'(WORD_BITS)) >= BASE_W'(lim_i);
  assign alloc_blk = base_q + BASE_W'(pick);

  assign bit_sel  = WORD_BITS'(1) << bit_q;
  assign bit_used = ram_rdata_i[bit_q];

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    kind_d      = kind_q;
    blk_d       = blk_q;
    word_d      = word_q;
    bit_d       = bit_q;
    base_d      = base_q;
    stat_d      = stat_q;
    rsp_valid_d = rsp_valid_q;
    rsp_stat_d  = rsp_stat_q;
    rsp_blk_d   = rsp_blk_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = word_q;
    ram_wdata_o = ram_rdata_i;
    ram_re_o    = 1'b0;
    ram_raddr_o = word_q;

    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = clr_q;
        ram_wdata_o = '0;
        clr_d       = clr_q + 1'b1;
        if (clr_q == ADDR_W'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          kind_d = req_i.kind;
          blk_d  = req_i.block_number;
          base_d = '0;
          word_d = '0;
          priority if (req_i.kind == KIND_OCCUPY || req_i.kind == KIND_RELEASE) begin
            if (CFG_W'(req_i.block_number) < lim_i) begin
              state_d = ST_DIV;
            end else begin
              stat_d  = STAT_RANGE;
              state_d = ST_FAIL;
            end
          end else if (req_i.kind == KIND_ALLOC) begin
            if (lim_i == '0) begin
              stat_d  = STAT_FULL;
              state_d = ST_FAIL;
            end else begin
              ram_re_o    = 1'b1;
              ram_raddr_o = '0;
              state_d     = ST_SCAN;
            end
          end else begin
            stat_d  = STAT_RANGE;
            state_d = ST_FAIL;
          end
        end
      end
      ST_DIV: begin
        word_d  = prod[SH +: ADDR_W];
        state_d = ST_RD;
      end
      ST_RD: begin
        ram_re_o = 1'b1;
        bit_d    = BIT_W'(blk_q - word_base);
        state_d  = ST_MOD;
      end
      ST_MOD: begin
        if (out_free) begin
          rsp_valid_d = 1'b1;
          rsp_blk_d   = '0;
          priority if (kind_q == KIND_OCCUPY && bit_used) begin
            rsp_stat_d = STAT_USED;
          end else if (kind_q == KIND_RELEASE && !bit_used) begin
            rsp_stat_d = STAT_FREE;
          end else begin
            ram_we_o    = 1'b1;
            ram_wdata_o = (kind_q == KIND_OCCUPY) ? (ram_rdata_i | bit_sel)
                                                  : (ram_rdata_i & ~bit_sel);
            rsp_stat_d  = STAT_DONE;
            rsp_blk_d   = blk_q;
          end
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        priority if (free_bits != '0) begin
          if (out_free) begin
            ram_we_o    = 1'b1;
            ram_wdata_o = ram_rdata_i | low_bit;
            rsp_valid_d = 1'b1;
            rsp_stat_d  = STAT_DONE;
            rsp_blk_d   = alloc_blk[BLK_W-1:0];
            state_d     = ST_IDLE;
          end
        end else if (last_word) begin
          if (out_free) begin
            rsp_valid_d = 1'b1;
            rsp_stat_d  = STAT_FULL;
            rsp_blk_d   = '0;
            state_d     = ST_IDLE;
          end
        end else begin
          // fetch the next word while this one is checked
          word_d      = word_q + 1'b1;
          base_d      = base_q + BASE_W'(WORD_BITS);
          ram_re_o    = 1'b1;
          ram_raddr_o = word_q + 1'b1;
        end
      end
      ST_FAIL: begin
        if (out_free) begin
          rsp_valid_d = 1'b1;
          rsp_stat_d  = stat_q;
          rsp_blk_d   = '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    blk_q      <= blk_d;
    word_q     <= word_d;
    bit_q      <= bit_d;
    base_q     <= base_d;
    stat_q     <= stat_d;
    rsp_stat_q <= rsp_stat_d;
    rsp_blk_q  <= rsp_blk_d;
  end

  // every map update after clearing flips exactly one bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o && state_q != ST_CLEAR |-> $countones(ram_wdata_o ^ ram_rdata_i) == 1)
    else $error("map update does not change exactly one bit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re_o |-> !ram_we_o)
    else $error("map read and write in the same cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q) != ST_IDLE && $past(state_q) != ST_CLEAR)
    else $error("result raised without a request in work");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && rsp_stat_q != STAT_DONE |-> rsp_blk_q == '0)
    else $error("failed result carries a block number");

endmodule

[hw/rtl/block_bitmap_allocator_core.sv]
// ----------------------------------------------------------------------------
// block_bitmap_allocator_core
// First-fit bitmap block allocator with occupy, release and allocate requests.
//
//   port           dir   handshake      payload
//   req_i          in    valid/ready    kind, block_number
//   rsp_o          out   valid/ready    status, result_block
//   cfg_we_i/wdata in    write enable   usable_blocks
//
// occupy and release step through accept, word index, map read, update
// allocate reads the map words it scans one per cycle on the single map
// read port, at most DEPTH of them
// after reset the map is cleared one word per cycle, all DEPTH words, no requests
// one request in work at a time; a held result stalls only the last step, the failure result or the map update
// ----------------------------------------------------------------------------
module block_bitmap_allocator_core import bba_pkg::*; #(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
  parameter int WORD_BITS  = WORD_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  bba_req_if.sink          req_i,
  bba_rsp_if.source        rsp_o,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  localparam int MAX_LIM = (NUM_BLOCKS < (1 << CFG_W) - 1) ? NUM_BLOCKS : (1 << CFG_W) - 1;
  localparam int DEPTH   = (MAX_LIM + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CFG_W-1:0]     usable_q;
  logic [CFG_W-1:0]     lim;
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      usable_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      usable_q <= cfg_wdata_i;
    end
  end

  // blocks at or past the smaller of register and map size are out of range
  assign lim = (usable_q < CFG_W'(MAX_LIM)) ? usable_q : CFG_W'(MAX_LIM);

  bba_ctrl #(
    .WORD_BITS  (WORD_BITS),
    .DEPTH      (DEPTH),
    .ADDR_W     (ADDR_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .lim_i       (lim),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  bba_map_ram #(
    .WORD_BITS (WORD_BITS),
    .DEPTH     (DEPTH),
    .ADDR_W    (ADDR_W)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule
